// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle check
`define YRGB_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle check
`define YRGB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/yrgb_pkg.sv =====
package yrgb_pkg;

  localparam int unsigned NUM_LANES = 6;
  localparam int unsigned NUM_TERMS = 3;
  localparam int unsigned TERM_W    = 20;

  localparam logic DIR_TO_RGB = 1'b0;
  localparam logic DIR_TO_YUV = 1'b1;

  localparam logic [2:0] BYTES_FWD = 3'd6;
  localparam logic [2:0] BYTES_REV = 3'd4;

  localparam logic signed [11:0] K_298 = 12'sd298;
  localparam logic signed [11:0] K_409 = 12'sd409;
  localparam logic signed [11:0] K_100 = 12'sd100;
  localparam logic signed [11:0] K_208 = 12'sd208;
  localparam logic signed [11:0] K_516 = 12'sd516;
  localparam logic signed [11:0] K_66  = 12'sd66;
  localparam logic signed [11:0] K_129 = 12'sd129;
  localparam logic signed [11:0] K_25  = 12'sd25;
  localparam logic signed [11:0] K_112 = 12'sd112;
  localparam logic signed [11:0] K_38  = 12'sd38;
  localparam logic signed [11:0] K_74  = 12'sd74;
  localparam logic signed [11:0] K_94  = 12'sd94;
  localparam logic signed [11:0] K_18  = 12'sd18;

  localparam logic signed [TERM_W-1:0] ROUND_BIAS = 20'sd128;

  localparam logic signed [12:0] OFS_NONE   = 13'sd0;
  localparam logic signed [12:0] OFS_LUMA   = 13'sd16;
  localparam logic signed [12:0] OFS_CHROMA = 13'sd128;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
  } yrgb_stage_en_t;

  function automatic logic signed [TERM_W-1:0] mul_k(input logic signed [9:0] x,
                                                     input logic signed [11:0] k);
    logic signed [TERM_W-1:0] p;
    p = x * k;
    return p;
  endfunction

  function automatic logic [7:0] sat8(input logic signed [12:0] v);
    logic [7:0] r;
    if (v < 13'sd0) begin
      r = 8'd0;
    end else if (v > 13'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// ===== src/yuv422_rgb_color_convert_unit.sv =====
// BT.601 color conversion between packed UYVY 4:2:2 and RGB888, one pixel
// pair per word.
// Input stream in_*: six source bytes in in_tdata, end-of-image in in_tlast.
// Forward: U, Y0, V, Y1 (bytes 4 and 5 unused). Reverse: R0 G0 B0 R1 G1 B1.
// Output stream out_*: six result bytes plus a 3-bit byte count in
// out_tdata, in_tlast copied to out_tlast. Reverse mode gives U Y0 V Y1, 0, 0.
// cfg_we/cfg_wdata set the direction (0 to RGB, 1 to UYVY); change it only
// while the pipe is empty. Each word uses the direction current at its accept.
// A word passes through three register stages (products, sums, clamp) before
// out_tvalid rises. Throughput: one word per cycle while out_tready is high.
// A stall on out_tready holds the output word; bubbles in the pipe still
// fill, and in_tready drops only once all three stages hold words.
// Reset (rst_n low, synchronous) empties the pipe and sets direction to 0.
`include "assert_macros.svh"

module yuv422_rgb_color_convert_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,      // direction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,       // src_byte0 .. src_byte5, 8 bits each
  input  logic        in_tlast,       // last_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,      // dst_byte0 .. dst_byte5, byte_count, 5'b0
  output logic        out_tlast       // last_out
);

  logic                     dir_r;
  logic                     s1_v_r, s2_v_r, s3_v_r;
  yrgb_pkg::yrgb_stage_en_t en;
  logic [7:0]               src_byte [6];
  logic [7:0]               dst_byte [6];
  logic [2:0]               byte_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= yrgb_pkg::DIR_TO_RGB;
    end else if (cfg_we) begin
      dir_r <= cfg_wdata;
    end
  end

  always_comb begin
    en.en3 = !s3_v_r || out_tready;
    en.en2 = !s2_v_r || en.en3;
    en.en1 = !s1_v_r || en.en2;
  end

  assign in_tready = en.en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (en.en1) begin
        s1_v_r <= in_tvalid;
      end
      if (en.en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en.en3) begin
        s3_v_r <= s2_v_r;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      src_byte[i] = in_tdata[8*i +: 8];
    end
  end

  yrgb_datapath u_datapath (
    .clk        (clk),
    .en         (en),
    .dir        (dir_r),
    .src_byte   (src_byte),
    .last_in    (in_tlast),
    .dst_byte   (dst_byte),
    .byte_count (byte_count),
    .last_out   (out_tlast)
  );

  assign out_tvalid = s3_v_r;
  assign out_tdata  = {5'b00000, byte_count, dst_byte[5], dst_byte[4], dst_byte[3],
                       dst_byte[2], dst_byte[1], dst_byte[0]};

  `YRGB_ASSERT(a_count_legal, out_tvalid,
               byte_count == yrgb_pkg::BYTES_FWD || byte_count == yrgb_pkg::BYTES_REV,
               "byte count not 4 or 6")
  `YRGB_ASSERT(a_rev_zero_tail, out_tvalid && byte_count == yrgb_pkg::BYTES_REV,
               out_tdata[47:32] == 16'd0, "reverse word has nonzero tail bytes")
  `YRGB_ASSERT(a_full_on_block, !in_tready,
               s1_v_r && s2_v_r && s3_v_r && !out_tready, "input blocked with room in pipe")
  `YRGB_ASSERT_NXT(a_accept_fills, in_tvalid && in_tready, s1_v_r,
                   "accepted word missing from first stage")

endmodule

// ===== src/yrgb_datapath.sv =====
module yrgb_datapath (
  input  logic                        clk,
  input  yrgb_pkg::yrgb_stage_en_t    en,
  input  logic                        dir,
  input  logic [7:0]                  src_byte [6],
  input  logic                        last_in,
  output logic [7:0]                  dst_byte [6],
  output logic [2:0]                  byte_count,
  output logic                        last_out
);

  logic signed [yrgb_pkg::TERM_W-1:0] s1_term_r   [6][3];
  logic signed [yrgb_pkg::TERM_W-1:0] s1_term_nxt [6][3];
  logic                               s1_dir_r;
  logic                               s1_last_r;

  logic signed [yrgb_pkg::TERM_W-1:0] s2_sum_r   [6];
  logic                               s2_dir_r;
  logic                               s2_last_r;

  logic [7:0]                         s3_byte_r   [6];
  logic [7:0]                         s3_byte_nxt [6];
  logic                               s3_dir_r;
  logic                               s3_last_r;

  logic signed [9:0] c0, c1, d, e;
  logic signed [9:0] r0, g0, b0, r1, g1, b1;
  logic signed [12:0] ofs [6];

  // stage 1: constant products
  always_comb begin
    c0 = $signed({2'b00, src_byte[1]}) - 10'sd16;
    c1 = $signed({2'b00, src_byte[3]}) - 10'sd16;
    d  = $signed({2'b00, src_byte[0]}) - 10'sd128;
    e  = $signed({2'b00, src_byte[2]}) - 10'sd128;
    r0 = $signed({2'b00, src_byte[0]});
    g0 = $signed({2'b00, src_byte[1]});
    b0 = $signed({2'b00, src_byte[2]});
    r1 = $signed({2'b00, src_byte[3]});
    g1 = $signed({2'b00, src_byte[4]});
    b1 = $signed({2'b00, src_byte[5]});
    for (int i = 0; i < 6; i++) begin
      for (int j = 0; j < 3; j++) begin
        s1_term_nxt[i][j] = '0;
      end
    end
    if (dir == yrgb_pkg::DIR_TO_RGB) begin
      s1_term_nxt[0][0] = yrgb_pkg::mul_k(c0, yrgb_pkg::K_298);
      s1_term_nxt[0][1] = yrgb_pkg::mul_k(e, yrgb_pkg::K_409);
      s1_term_nxt[1][0] = yrgb_pkg::mul_k(c0, yrgb_pkg::K_298);
      s1_term_nxt[1][1] = -yrgb_pkg::mul_k(d, yrgb_pkg::K_100);
      s1_term_nxt[1][2] = -yrgb_pkg::mul_k(e, yrgb_pkg::K_208);
      s1_term_nxt[2][0] = yrgb_pkg::mul_k(c0, yrgb_pkg::K_298);
      s1_term_nxt[2][1] = yrgb_pkg::mul_k(d, yrgb_pkg::K_516);
      s1_term_nxt[3][0] = yrgb_pkg::mul_k(c1, yrgb_pkg::K_298);
      s1_term_nxt[3][1] = yrgb_pkg::mul_k(e, yrgb_pkg::K_409);
      s1_term_nxt[4][0] = yrgb_pkg::mul_k(c1, yrgb_pkg::K_298);
      s1_term_nxt[4][1] = -yrgb_pkg::mul_k(d, yrgb_pkg::K_100);
      s1_term_nxt[4][2] = -yrgb_pkg::mul_k(e, yrgb_pkg::K_208);
      s1_term_nxt[5][0] = yrgb_pkg::mul_k(c1, yrgb_pkg::K_298);
      s1_term_nxt[5][1] = yrgb_pkg::mul_k(d, yrgb_pkg::K_516);
    end else begin
      s1_term_nxt[0][0] = -yrgb_pkg::mul_k(r0, yrgb_pkg::K_38);
      s1_term_nxt[0][1] = -yrgb_pkg::mul_k(g0, yrgb_pkg::K_74);
      s1_term_nxt[0][2] = yrgb_pkg::mul_k(b0, yrgb_pkg::K_112);
      s1_term_nxt[1][0] = yrgb_pkg::mul_k(r0, yrgb_pkg::K_66);
      s1_term_nxt[1][1] = yrgb_pkg::mul_k(g0, yrgb_pkg::K_129);
      s1_term_nxt[1][2] = yrgb_pkg::mul_k(b0, yrgb_pkg::K_25);
      s1_term_nxt[2][0] = yrgb_pkg::mul_k(r1, yrgb_pkg::K_112);
      s1_term_nxt[2][1] = -yrgb_pkg::mul_k(g1, yrgb_pkg::K_94);
      s1_term_nxt[2][2] = -yrgb_pkg::mul_k(b1, yrgb_pkg::K_18);
      s1_term_nxt[3][0] = yrgb_pkg::mul_k(r1, yrgb_pkg::K_66);
      s1_term_nxt[3][1] = yrgb_pkg::mul_k(g1, yrgb_pkg::K_129);
      s1_term_nxt[3][2] = yrgb_pkg::mul_k(b1, yrgb_pkg::K_25);
    end
  end

  always_ff @(posedge clk) begin
    if (en.en1) begin
      s1_term_r <= s1_term_nxt;
      s1_dir_r  <= dir;
      s1_last_r <= last_in;
    end
  end

  // stage 2: rounded sums
  always_ff @(posedge clk) begin
    if (en.en2) begin
      for (int i = 0; i < 6; i++) begin
        s2_sum_r[i] <= s1_term_r[i][0] + s1_term_r[i][1] + s1_term_r[i][2]
                       + yrgb_pkg::ROUND_BIAS;
      end
      s2_dir_r  <= s1_dir_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: shift, offset, clamp
  always_comb begin
    if (s2_dir_r == yrgb_pkg::DIR_TO_RGB) begin
      for (int i = 0; i < 6; i++) begin
        ofs[i] = yrgb_pkg::OFS_NONE;
      end
    end else begin
      ofs[0] = yrgb_pkg::OFS_CHROMA;
      ofs[1] = yrgb_pkg::OFS_LUMA;
      ofs[2] = yrgb_pkg::OFS_CHROMA;
      ofs[3] = yrgb_pkg::OFS_LUMA;
      ofs[4] = yrgb_pkg::OFS_NONE;
      ofs[5] = yrgb_pkg::OFS_NONE;
    end
    for (int i = 0; i < 6; i++) begin
      s3_byte_nxt[i] = yrgb_pkg::sat8($signed({s2_sum_r[i][19], s2_sum_r[i][19:8]}) + ofs[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en.en3) begin
      s3_byte_r <= s3_byte_nxt;
      s3_dir_r  <= s2_dir_r;
      s3_last_r <= s2_last_r;
    end
  end

  assign dst_byte   = s3_byte_r;
  assign byte_count = (s3_dir_r == yrgb_pkg::DIR_TO_RGB) ? yrgb_pkg::BYTES_FWD
                                                         : yrgb_pkg::BYTES_REV;
  assign last_out   = s3_last_r;

endmodule
